// ----- src/esc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// Shared widths, constants and sideband types of the earth shadow classifier.
// ----------------------------------------------------------------------------
package esc_pkg;

   localparam int SUN_W  = 29;
   localparam int POS_W  = 32;
   localparam int DVD_W  = 61;   // dividend, positive dot product magnitude
   localparam int S2_W   = 58;   // squared sun vector length
   localparam int P2_W   = 64;   // squared position length, fits without wrapping
   localparam int QUO_W  = 32;
   localparam int TAN_W  = 25;
   localparam int RAD_W  = 25;

   localparam logic [RAD_W-1:0] EARTH_RADIUS = 25'd6378137;
   localparam logic [TAN_W-1:0] TAN_PEN      = 25'd20165061;
   localparam logic [TAN_W-1:0] TAN_UMB      = 25'd19798840;

   localparam logic [1:0] CLS_NONE = 2'd0;
   localparam logic [1:0] CLS_PEN  = 2'd1;
   localparam logic [1:0] CLS_UMB  = 2'd2;

   typedef struct packed {
      logic [DVD_W-1:0] dvd;
      logic [P2_W-1:0]  p2;
      logic             dpos;
   } frt_side_type;

   typedef struct packed {
      logic [P2_W-1:0] p2;
      logic            dpos;
   } div_side_type;

   typedef struct packed {
      logic [QUO_W-1:0] quo;
      logic             big;
      logic [P2_W-1:0]  p2;
      logic             dpos;
   } sqp_side_type;

endpackage

// ----- src/esc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_front
// Two stages: component products, then dot product and squared lengths.
// ----------------------------------------------------------------------------
module esc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_vld,
   input  logic [esc_pkg::SUN_W-1:0]    sun_x,
   input  logic [esc_pkg::SUN_W-1:0]    sun_y,
   input  logic [esc_pkg::SUN_W-1:0]    sun_z,
   input  logic [esc_pkg::POS_W-1:0]    pos_x,
   input  logic [esc_pkg::POS_W-1:0]    pos_y,
   input  logic [esc_pkg::POS_W-1:0]    pos_z,
   output logic                         out_vld,
   output logic [esc_pkg::S2_W-1:0]     s2,
   output esc_pkg::frt_side_type        side
);
   import esc_pkg::*;

   localparam int PR_W = SUN_W + POS_W;

   logic signed [PR_W-1:0]  dx_ff, dy_ff, dz_ff;
   logic signed [S2_W-1:0]  sx2_ff, sy2_ff, sz2_ff;
   logic signed [P2_W-1:0]  px2_ff, py2_ff, pz2_ff;
   logic                    vld1_ff, vld2_ff;
   logic [S2_W-1:0]         s2_ff;
   frt_side_type            side_ff;

   logic signed [PR_W:0]    dot_in;
   logic signed [PR_W:0]    neg_in;
   logic                    dpos_in;
   frt_side_type            side_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff  <= $signed(sun_x) * $signed(pos_x);
         dy_ff  <= $signed(sun_y) * $signed(pos_y);
         dz_ff  <= $signed(sun_z) * $signed(pos_z);
         sx2_ff <= $signed(sun_x) * $signed(sun_x);
         sy2_ff <= $signed(sun_y) * $signed(sun_y);
         sz2_ff <= $signed(sun_z) * $signed(sun_z);
         px2_ff <= $signed(pos_x) * $signed(pos_x);
         py2_ff <= $signed(pos_y) * $signed(pos_y);
         pz2_ff <= $signed(pos_z) * $signed(pos_z);
      end
   end

   always_comb begin
      dot_in       = (PR_W+1)'(dx_ff) + (PR_W+1)'(dy_ff) + (PR_W+1)'(dz_ff);
      neg_in       = -dot_in;
      dpos_in      = neg_in > 0;
      side_in.dpos = dpos_in;
      // non-positive projection: feed zero so the divider stays harmless
      side_in.dvd  = dpos_in ? neg_in[DVD_W-1:0] : '0;
      side_in.p2   = px2_ff + py2_ff + pz2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff   <= sx2_ff + sy2_ff + sz2_ff;
         side_ff <= side_in;
      end
   end

   assign out_vld = vld2_ff;
   assign s2      = s2_ff;
   assign side    = side_ff;

endmodule

// ----- src/esc_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_isqrt
// Pipelined integer square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
module esc_isqrt #(
   parameter int W  = 64,
   parameter int SW = 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_vld,
   input  logic [W-1:0]   rad_i,
   input  logic [SW-1:0]  side_i,
   output logic           out_vld,
   output logic [W/2-1:0] root_o,
   output logic [SW-1:0]  side_o
);
   localparam int H = W / 2;

   logic [W-1:0]  rem_ff  [H];
   logic [H-1:0]  root_ff [H];
   logic [SW-1:0] side_ff [H];
   logic          vld_ff  [H];

   for (genvar i = 0; i < H; i++) begin : g_stage
      localparam int K = H - 1 - i;
      logic [W-1:0]  rem_src;
      logic [H-1:0]  root_src;
      logic [SW-1:0] side_src;
      logic          vld_src;
      logic [W+1:0]  trial;
      logic          fit;
      logic [W-1:0]  rem_in;
      logic [H-1:0]  root_in;

      if (i == 0) begin : g_first
         assign rem_src  = rad_i;
         assign root_src = '0;
         assign side_src = side_i;
         assign vld_src  = in_vld;
      end else begin : g_next
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
         assign side_src = side_ff[i-1];
         assign vld_src  = vld_ff[i-1];
      end

      // (2r + 2^k) * 2^k against what is left of the radicand
      assign trial   = ((W+2)'(root_src) << (K + 1)) | ((W+2)'(1) << (2 * K));
      assign fit     = {2'b00, rem_src} >= trial;
      assign rem_in  = fit ? rem_src - trial[W-1:0] : rem_src;
      assign root_in = fit ? (root_src | (H'(1) << K)) : root_src;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            side_ff[i] <= side_src;
         end
      end
   end

   assign out_vld = vld_ff[H-1];
   assign root_o  = root_ff[H-1];
   assign side_o  = side_ff[H-1];

endmodule

// ----- src/esc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_div
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow flag for quotients that do not fit the quotient width.
// ----------------------------------------------------------------------------
module esc_div #(
   parameter int DW = 61,
   parameter int NW = 29,
   parameter int QW = 32,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_vld,
   input  logic [DW-1:0] dvd_i,
   input  logic [NW-1:0] dvs_i,
   input  logic [SW-1:0] side_i,
   output logic          out_vld,
   output logic [QW-1:0] quo_o,
   output logic          big_o,
   output logic [SW-1:0] side_o
);
   logic [DW-1:0] rem_ff  [QW+1];
   logic [NW-1:0] dvs_ff  [QW+1];
   logic [QW-1:0] quo_ff  [QW+1];
   logic          big_ff  [QW+1];
   logic [SW-1:0] side_ff [QW+1];
   logic          vld_ff  [QW+1];

   logic          big_in;

   // quotient reaches 2^QW or more
   assign big_in = {1'b0, dvd_i} >= ((DW+1)'(dvs_i) << QW);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= dvd_i;
         dvs_ff[0]  <= dvs_i;
         quo_ff[0]  <= '0;
         big_ff[0]  <= big_in;
         side_ff[0] <= side_i;
      end
   end

   for (genvar i = 1; i <= QW; i++) begin : g_stage
      localparam int K = QW - i;
      logic [DW:0]   sub;
      logic          fit;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      assign sub    = (DW+1)'(dvs_ff[i-1]) << K;
      assign fit    = {1'b0, rem_ff[i-1]} >= sub;
      assign rem_in = fit ? rem_ff[i-1] - sub[DW-1:0] : rem_ff[i-1];
      assign quo_in = fit ? (quo_ff[i-1] | (QW'(1) << K)) : quo_ff[i-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in;
            dvs_ff[i]  <= dvs_ff[i-1];
            quo_ff[i]  <= quo_in;
            big_ff[i]  <= big_ff[i-1];
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_vld = vld_ff[QW];
   assign quo_o   = quo_ff[QW];
   assign big_o   = big_ff[QW];
   assign side_o  = side_ff[QW];

endmodule

// ----- src/esc_post.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_post
// Clamps the axial distance, forms both cone radii and squares, and
// compares against the squared off-axis distance.
// ----------------------------------------------------------------------------
module esc_post (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_vld,
   input  logic [esc_pkg::QUO_W-1:0]   pn,
   input  esc_pkg::sqp_side_type       side,
   output logic                        out_vld,
   output logic [1:0]                  cls
);
   import esc_pkg::*;

   localparam int TP_W = QUO_W + TAN_W;

   logic                  vld_ff [5];
   logic [QUO_W-1:0]      h_ff;
   logic [P2_W-1:0]       p2a_ff, p2b_ff;
   logic                  dpa_ff, dpb_ff, dpc_ff, dpd_ff;
   logic [P2_W-1:0]       hh_ff;
   logic [TP_W-1:0]       tp_ff, tu_ff;
   logic [P2_W-1:0]       v2a_ff, v2b_ff;
   logic [RAD_W-1:0]      pr_ff;
   logic signed [RAD_W:0] ur_ff;
   logic [2*RAD_W-1:0]    prsq_ff, ursq_ff;
   logic                  uneg_ff;
   logic [1:0]            cls_ff;

   logic [QUO_W-1:0]      h_in;
   logic [RAD_W-1:0]      umag_in;
   logic [1:0]            cls_in;

   assign h_in    = (side.big || side.quo > pn) ? pn : side.quo;
   assign umag_in = ur_ff[RAD_W-1:0];

   always_comb begin
      cls_in = CLS_NONE;
      if (dpd_ff && v2b_ff <= P2_W'(prsq_ff)) begin
         cls_in = CLS_PEN;
         if (!uneg_ff && v2b_ff <= P2_W'(ursq_ff)) begin
            cls_in = CLS_UMB;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
         for (int i = 1; i < 5; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_ff    <= h_in;
         p2a_ff  <= side.p2;
         dpa_ff  <= side.dpos;

         hh_ff   <= P2_W'(h_ff) * P2_W'(h_ff);
         tp_ff   <= TP_W'(h_ff) * TP_W'(TAN_PEN);
         tu_ff   <= TP_W'(h_ff) * TP_W'(TAN_UMB);
         p2b_ff  <= p2a_ff;
         dpb_ff  <= dpa_ff;

         v2a_ff  <= p2b_ff - hh_ff;
         pr_ff   <= EARTH_RADIUS + tp_ff[TP_W-1:QUO_W];
         ur_ff   <= $signed({1'b0, EARTH_RADIUS}) - $signed({1'b0, tu_ff[TP_W-1:QUO_W]});
         dpc_ff  <= dpb_ff;

         prsq_ff <= (2*RAD_W)'(pr_ff) * (2*RAD_W)'(pr_ff);
         ursq_ff <= (2*RAD_W)'(umag_in) * (2*RAD_W)'(umag_in);
         uneg_ff <= ur_ff[RAD_W];
         v2b_ff  <= v2a_ff;
         dpd_ff  <= dpc_ff;

         cls_ff  <= cls_in;
      end
   end

   assign out_vld = vld_ff[4];
   assign cls     = cls_ff;

endmodule

// ----- src/earth_shadow_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earth_shadow_classifier
// Conical earth shadow test: none, penumbra or umbra for each request.
//
//  channel  dir  ports                   contents
//  req      in   req_tvalid/tready/tdata sun vector (km), position (m)
//  rsp      out  rsp_tvalid/tready/tdata shadow class
//
// One request per cycle while the response is accepted, through 2 front stages,
// 29 sun root stages, 33 divider stages, 32 position root stages, 5 back.
// Pipeline depth is set by the bit-per-stage root and divider pipelines.
// Synchronous reset clears only the valid bits.
// A stalled result freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module earth_shadow_classifier (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // sun_x, sun_y, sun_z, pos_x, pos_y, pos_z, one zero pad bit
   input  logic [183:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // shadow_class, six zero pad bits
   output logic [7:0]   rsp_tdata
);
   import esc_pkg::*;

   logic                 en;
   logic                 frt_vld, sqs_vld, div_vld, sqp_vld, post_vld;
   logic [S2_W-1:0]      s2;
   frt_side_type         frt_side, sqs_side;
   logic [S2_W/2-1:0]    n_root;
   div_side_type         div_in_side, div_out_side;
   logic [QUO_W-1:0]     quo;
   logic                 big;
   sqp_side_type         sqp_in_side, sqp_out_side;
   logic [QUO_W-1:0]     pn;
   logic [1:0]           cls;

   assign en         = !post_vld || rsp_tready;
   assign req_tready = en;

   esc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (req_tvalid),
      .sun_x   (req_tdata[28:0]),
      .sun_y   (req_tdata[57:29]),
      .sun_z   (req_tdata[86:58]),
      .pos_x   (req_tdata[118:87]),
      .pos_y   (req_tdata[150:119]),
      .pos_z   (req_tdata[182:151]),
      .out_vld (frt_vld),
      .s2      (s2),
      .side    (frt_side)
   );

   esc_isqrt #(.W(S2_W), .SW($bits(frt_side_type))) u_sqrt_sun (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (frt_vld),
      .rad_i   (s2),
      .side_i  (frt_side),
      .out_vld (sqs_vld),
      .root_o  (n_root),
      .side_o  (sqs_side)
   );

   assign div_in_side.p2   = sqs_side.p2;
   assign div_in_side.dpos = sqs_side.dpos;

   esc_div #(.DW(DVD_W), .NW(S2_W/2), .QW(QUO_W), .SW($bits(div_side_type))) u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (sqs_vld),
      .dvd_i   (sqs_side.dvd),
      .dvs_i   (n_root),
      .side_i  (div_in_side),
      .out_vld (div_vld),
      .quo_o   (quo),
      .big_o   (big),
      .side_o  (div_out_side)
   );

   assign sqp_in_side.quo  = quo;
   assign sqp_in_side.big  = big;
   assign sqp_in_side.p2   = div_out_side.p2;
   assign sqp_in_side.dpos = div_out_side.dpos;

   esc_isqrt #(.W(P2_W), .SW($bits(sqp_side_type))) u_sqrt_pos (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (div_vld),
      .rad_i   (div_out_side.p2),
      .side_i  (sqp_in_side),
      .out_vld (sqp_vld),
      .root_o  (pn),
      .side_o  (sqp_out_side)
   );

   esc_post u_post (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (sqp_vld),
      .pn      (pn),
      .side    (sqp_out_side),
      .out_vld (post_vld),
      .cls     (cls)
   );

   assign rsp_tvalid = post_vld;
   assign rsp_tdata  = {6'b000000, cls};

endmodule
